// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the frame allocator modules.
// Each module that uses them must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is held.
`define DFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define DFA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/dfa_pkg.sv =====
// Shared types and constants of the double-ended frame allocator.
// No dependencies; used by dfa_ctrl, dfa_dp and the top level.
`default_nettype none

package dfa_pkg;

    localparam int unsigned MARKER_DEPTH = 8;
    localparam int unsigned CNT_W  = $clog2(MARKER_DEPTH + 1);
    localparam int unsigned IDX_W  = (MARKER_DEPTH > 1) ? $clog2(MARKER_DEPTH) : 1;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PTR_W  = ADDR_W + 1;
    localparam int unsigned SIZE_W = 21;

    localparam logic [ADDR_W-1:0] BASE_RST = 32'd0;
    localparam logic [SIZE_W-1:0] SIZE_RST = 21'd1048576;

    typedef enum logic [1:0] {
        ACT_ALLOC     = 2'd0,
        ACT_MARK_SET  = 2'd1,
        ACT_MARK_FREE = 2'd2,
        ACT_INIT      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALIGN,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic load;
        logic align;
        logic commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/dfa_ctrl.sv =====
// Controller of the frame allocator: sequences load, align and commit steps
// and owns the output word valid flag. Depends on dfa_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dfa_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    output dfa_pkg::t_dp_cmd o_cmd
);

    dfa_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dfa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            dfa_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dfa_pkg::S_ALIGN;
                end
            end
            dfa_pkg::S_ALIGN: begin
                o_cmd.align = 1'b1;
                n_state     = dfa_pkg::S_DECIDE;
            end
            dfa_pkg::S_DECIDE: begin
                // hold the result until the output register frees up
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = dfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dfa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    `DFA_ASSERT(a_commit_slot_free, o_cmd.commit |-> (!r_out_valid || i_m_tready), "commit over a pending word")
    `DFA_ASSERT(a_load_then_align, o_cmd.load |=> (r_state == dfa_pkg::S_ALIGN), "load not followed by align")
    `DFA_ASSERT(a_commit_shows_word, o_cmd.commit |=> o_m_tvalid, "committed word not presented")

endmodule

`default_nettype wire

// ===== rtl/core/dfa_dp.sv =====
// Datapath of the frame allocator: pointers, marker stacks, alignment and
// crossing checks, result registers. Depends on dfa_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module dfa_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  dfa_pkg::t_dp_cmd             i_cmd,
    input  wire [dfa_pkg::ADDR_W-1:0]    i_cfg_base,
    input  wire [dfa_pkg::SIZE_W-1:0]    i_cfg_size,
    input  wire [1:0]                    i_action,
    input  wire                          i_end_select,
    input  wire [dfa_pkg::SIZE_W-1:0]    i_request_size,
    output logic                         o_ok,
    output logic [dfa_pkg::ADDR_W-1:0]   o_address,
    output logic [dfa_pkg::ADDR_W-1:0]   o_clear_start,
    output logic [dfa_pkg::SIZE_W-1:0]   o_clear_length
);

    localparam int unsigned PW = dfa_pkg::PTR_W;
    localparam int unsigned SW = dfa_pkg::SIZE_W;
    localparam int unsigned CW = dfa_pkg::CNT_W;
    localparam int unsigned IW = dfa_pkg::IDX_W;
    localparam int unsigned AW = dfa_pkg::ADDR_W;

    // pointer and stack state
    logic [PW-1:0] r_bot, n_bot, r_top, n_top;
    logic [CW-1:0] r_bot_cnt, n_bot_cnt, r_top_cnt, n_top_cnt;
    logic [PW-1:0] r_bot_mk [dfa_pkg::MARKER_DEPTH];
    logic [PW-1:0] r_top_mk [dfa_pkg::MARKER_DEPTH];

    // latched request
    dfa_pkg::t_action r_act;
    logic             r_end;
    logic [SW-1:0]    r_size;

    // align stage results
    logic [PW-1:0] r_aligned, r_mark;
    logic          r_zero, r_under;

    // result registers
    logic          r_ok, n_ok;
    logic [PW-1:0] r_addr, n_addr, r_cstart, n_cstart;
    logic [SW-1:0] r_clen, n_clen;

    logic [PW-1:0] w_size_ext, w_mask, w_up, w_dn;
    logic [CW-1:0] w_bot_pop, w_top_pop;
    logic [PW:0]   w_end_sum;
    logic          w_bot_room, w_top_room;
    logic          w_push_bot, w_push_top;
    logic [PW-1:0] w_hi, w_lo, w_diff;
    logic [SW-1:0] w_len;

    assign w_size_ext = PW'(r_size);
    assign w_mask     = PW'(r_size - SW'(1));
    assign w_up       = r_bot + w_mask;
    assign w_dn       = r_top - w_size_ext;
    assign w_bot_pop  = r_bot_cnt - CW'(1);
    assign w_top_pop  = r_top_cnt - CW'(1);
    assign w_bot_room = r_bot_cnt < CW'(dfa_pkg::MARKER_DEPTH);
    assign w_top_room = r_top_cnt < CW'(dfa_pkg::MARKER_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= dfa_pkg::t_action'(i_action);
            r_end  <= i_end_select;
            r_size <= i_request_size;
        end
        if (i_cmd.align) begin
            r_aligned <= (r_end ? w_dn : w_up) & ~w_mask;
            r_zero    <= (r_size == '0);
            r_under   <= (w_size_ext > r_top);
            r_mark    <= r_end ? r_top_mk[w_top_pop[IW-1:0]] : r_bot_mk[w_bot_pop[IW-1:0]];
        end
    end

    // clear range after a free: bottom clears [marker, pointer), top [pointer, marker)
    assign w_hi   = r_end ? r_mark : r_bot;
    assign w_lo   = r_end ? r_top  : r_mark;
    assign w_diff = w_hi - w_lo;

    always_comb begin
        priority if (w_hi <= w_lo) begin
            w_len = '0;
        end else if (|w_diff[PW-1:SW]) begin
            w_len = '1;
        end else begin
            w_len = w_diff[SW-1:0];
        end
    end

    assign w_end_sum = {1'b0, r_aligned} + (PW+1)'(r_size);

    always_comb begin
        n_bot      = r_bot;
        n_top      = r_top;
        n_bot_cnt  = r_bot_cnt;
        n_top_cnt  = r_top_cnt;
        n_ok       = 1'b0;
        n_addr     = '0;
        n_cstart   = '0;
        n_clen     = '0;
        w_push_bot = 1'b0;
        w_push_top = 1'b0;
        unique case (r_act)
            dfa_pkg::ACT_ALLOC: begin
                if (!r_end) begin
                    if (!r_zero && (w_end_sum <= {1'b0, r_top})) begin
                        n_bot  = w_end_sum[PW-1:0];
                        n_addr = r_aligned;
                        n_ok   = 1'b1;
                    end
                end else if (!r_zero && !r_under && (r_aligned >= r_bot)) begin
                    n_top  = r_aligned;
                    n_addr = r_aligned;
                    n_ok   = 1'b1;
                end
            end
            dfa_pkg::ACT_MARK_SET: begin
                if (!r_end) begin
                    if (w_bot_room) begin
                        w_push_bot = 1'b1;
                        n_bot_cnt  = r_bot_cnt + CW'(1);
                        n_ok       = 1'b1;
                    end
                end else if (w_top_room) begin
                    w_push_top = 1'b1;
                    n_top_cnt  = r_top_cnt + CW'(1);
                    n_ok       = 1'b1;
                end
            end
            dfa_pkg::ACT_MARK_FREE: begin
                if (!r_end) begin
                    if (r_bot_cnt != '0) begin
                        n_bot_cnt = w_bot_pop;
                        n_cstart  = r_mark;
                        n_clen    = w_len;
                        n_bot     = r_mark;
                        n_addr    = r_mark;
                        n_ok      = 1'b1;
                    end
                end else if (r_top_cnt != '0) begin
                    n_top_cnt = w_top_pop;
                    n_cstart  = r_top;
                    n_clen    = w_len;
                    n_top     = r_mark;
                    n_addr    = r_mark;
                    n_ok      = 1'b1;
                end
            end
            dfa_pkg::ACT_INIT: begin
                n_bot = PW'(i_cfg_base);
                n_top = PW'(i_cfg_base) + PW'(i_cfg_size);
                n_ok  = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bot     <= PW'(dfa_pkg::BASE_RST);
            r_top     <= PW'(dfa_pkg::BASE_RST) + PW'(dfa_pkg::SIZE_RST);
            r_bot_cnt <= '0;
            r_top_cnt <= '0;
        end else if (i_cmd.commit) begin
            r_bot     <= n_bot;
            r_top     <= n_top;
            r_bot_cnt <= n_bot_cnt;
            r_top_cnt <= n_top_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_ok     <= n_ok;
            r_addr   <= n_addr;
            r_cstart <= n_cstart;
            r_clen   <= n_clen;
            if (w_push_bot) begin
                r_bot_mk[r_bot_cnt[IW-1:0]] <= r_bot;
            end
            if (w_push_top) begin
                r_top_mk[r_top_cnt[IW-1:0]] <= r_top;
            end
        end
    end

    assign o_ok           = r_ok;
    assign o_address      = r_addr[AW-1:0];
    assign o_clear_start  = r_cstart[AW-1:0];
    assign o_clear_length = r_clen;

    `DFA_ASSERT(a_bot_cnt_bound, r_bot_cnt <= CW'(dfa_pkg::MARKER_DEPTH), "bottom stack overrun")
    `DFA_ASSERT(a_top_cnt_bound, r_top_cnt <= CW'(dfa_pkg::MARKER_DEPTH), "top stack overrun")

endmodule

`default_nettype wire

// ===== rtl/core/double_ended_frame_allocator_unit.sv =====
// Double-ended frame allocator: one pool served from a bottom end growing up
// and a top end growing down, each with its own marker stack.
// Slave stream: one request word per handshake; tdata carries request_size,
// tuser carries action (allocate, set marker, free marker, init) and end.
// Master stream: one result word per request; tuser is the ok flag, tdata
// holds address, clear_start and clear_length.
// Timing: a request steps through capture, align (pointer round-up or
// round-down and marker stack read), decide and commit. The result word is
// valid the cycle after commit; the next request is taken while it waits.
// A new request is taken only after the previous one commits, set by the
// controller's three-step sequence around the single pointer update path.
// Receiver stall: a result not yet taken holds in the output register; a
// following request runs up to the commit step and waits there.
// Reset: pointers go to 0 and 1048576, marker counts to zero, pool_base and
// pool_size to 0 and 1048576. Register writes (APB, base at 0x0, size at
// 0x4) take effect at the next init request.
// Depends on dfa_pkg, dfa_ctrl and dfa_dp.
`default_nettype none

module double_ended_frame_allocator_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,   // [20:0] request_size, [23:21] zero
    input  wire  [2:0]  i_s_tuser,   // [1:0] action, [2] end_select
    // result stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [87:0] o_m_tdata,   // [31:0] address, [63:32] clear_start,
                                     // [84:64] clear_length, [87:85] zero
    output logic        o_m_tuser,   // [0] ok
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_POOL_BASE = 1'b0;
    localparam logic REG_POOL_SIZE = 1'b1;

    logic [dfa_pkg::ADDR_W-1:0] r_pool_base;
    logic [dfa_pkg::SIZE_W-1:0] r_pool_size;
    logic                       w_cfg_wr;
    dfa_pkg::t_dp_cmd           w_cmd;

    logic                       w_ok;
    logic [dfa_pkg::ADDR_W-1:0] w_address;
    logic [dfa_pkg::ADDR_W-1:0] w_clear_start;
    logic [dfa_pkg::SIZE_W-1:0] w_clear_length;

    // register file: no wait states
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= dfa_pkg::BASE_RST;
            r_pool_size <= dfa_pkg::SIZE_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_POOL_BASE: r_pool_base <= pwdata;
                REG_POOL_SIZE: r_pool_size <= pwdata[dfa_pkg::SIZE_W-1:0];
                default:       r_pool_base <= r_pool_base;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_POOL_BASE: prdata = r_pool_base;
            REG_POOL_SIZE: prdata = 32'(r_pool_size);
            default:       prdata = '0;
        endcase
    end

    dfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    dfa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_base     (r_pool_base),
        .i_cfg_size     (r_pool_size),
        .i_action       (i_s_tuser[1:0]),
        .i_end_select   (i_s_tuser[2]),
        .i_request_size (i_s_tdata[dfa_pkg::SIZE_W-1:0]),
        .o_ok           (w_ok),
        .o_address      (w_address),
        .o_clear_start  (w_clear_start),
        .o_clear_length (w_clear_length)
    );

    // pack the result word, lowest field first
    assign o_m_tdata = {3'b000, w_clear_length, w_clear_start, w_address};
    assign o_m_tuser = w_ok;

endmodule

`default_nettype wire
